// ===== rtl/lcc_pkg.sv =====
// lcc_pkg: shared widths, reset constants and controller state codes for the
// largest connected component block. No dependencies.
`default_nettype none

package lcc_pkg;

  // fixed field widths of the channels
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned VIDX_W  = 6;

  // vertex_count after reset
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EDGE_A = 7'b0000010,
    ST_EDGE_B = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_EXPAND = 7'b0010000,
    ST_PUSH   = 7'b0100000,
    ST_POP    = 7'b1000000
  } lcc_state_t;

endpackage

`default_nettype wire

// ===== rtl/largest_connected_component.sv =====
// largest_connected_component: top level, edge loader and depth-first walk.
// Depends on lcc_pkg, lcc_ram (adjacency rows and walk stack) and lcc_low_bit.
//
// Usage
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes vertex_count, reset value 64,
//   always ready; user must write it only while the block is idle; not enforced.
//   in channel: mode 0 adds edge vertex_a--vertex_b, mode 1 finishes the graph.
//   out channel: one largest_size transfer per finish item, none per edge.
//   in_ready is high only while the controller is idle, so items go one at a time.
// Item flow
//   edge item: a normal edge holds the input in EDGE_A then EDGE_B, a self loop
//   in EDGE_A only, a dropped edge not at all; one read-modify-write per
//   endpoint through the single write port of the adjacency memory.
//   finish item: the result is loaded once the walk has visited every live
//   vertex; each non-root vertex costs one push, one stack pop, one adjacency
//   row read and one empty check, a root one scan, one row read and one empty
//   check, and every row read waits on the registered memory read.
// Reset and stall
//   reset clears the per-row valid flags, so every row reads as no edges at once;
//   the same flags drop together as each finish loads its result; no clearing pass.
//   the result sits in an output register; edge items keep flowing while it
//   waits, and a later finish holds at its end until the previous result leaves.
`default_nettype none

module largest_connected_component
  import lcc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mode,
  input  wire logic [VIDX_W-1:0]  vertex_a,
  input  wire logic [VIDX_W-1:0]  vertex_b,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [COUNT_W-1:0] largest_size
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  lcc_state_t state;

  logic [COUNT_W-1:0]      vertex_count;
  logic [CW-1:0]           eff_count;
  logic [MAX_VERTICES-1:0] live;
  logic                    edge_ok;

  // adjacency memory and its row valid flags
  logic                    adj_we, adj_re;
  logic [IW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, row_cur;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    adj_rd_ok;

  // walk stack memory
  logic                    stk_we, stk_re;
  logic [IW-1:0]           stk_waddr, stk_raddr;
  logic [IW-1:0]           stk_wdata, stk_rdata;

  // walk registers
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] frontier;
  logic [MAX_VERTICES-1:0] cand;
  logic [IW-1:0]           sp;
  logic [CW-1:0]           cur_count;
  logic [CW-1:0]           best;
  logic [IW-1:0]           edge_a, edge_b;
  logic                    result_load;

  // lowest-bit finder shared by start scan and push
  logic [MAX_VERTICES-1:0] lb_vec;
  logic [IW-1:0]           lb_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // vertex count clamped to 1 .. MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      eff_count = CW'(1);
    end else if (vertex_count > COUNT_W'(MAX_VERTICES)) begin
      eff_count = CW'(MAX_VERTICES);
    end else begin
      eff_count = CW'(vertex_count);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i] = (CW'(i) < eff_count);
    end
  end

  // edges naming a vertex outside the graph are dropped
  assign edge_ok = ({1'b0, vertex_a} < COUNT_W'(eff_count)) &&
                   ({1'b0, vertex_b} < COUNT_W'(eff_count));

  // a row never written since the last clear reads as empty
  assign row_cur = adj_rd_ok ? adj_rdata : '0;
  assign cand    = live & ~visited;
  assign lb_vec  = (state == ST_SCAN) ? cand : frontier;

  // walk done and the output register free
  assign result_load = (state == ST_SCAN) && (cand == '0) && (!out_valid || out_ready);

  lcc_low_bit #(
    .WIDTH (MAX_VERTICES)
  ) u_low_bit (
    .vec (lb_vec),
    .idx (lb_idx)
  );

  lcc_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  lcc_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // memory port control
  always_comb begin
    adj_we    = 1'b0;
    adj_re    = 1'b0;
    adj_waddr = '0;
    adj_raddr = '0;
    adj_wdata = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = '0;
    stk_raddr = '0;
    stk_wdata = '0;
    case (state)
      ST_IDLE: begin
        // fetch row a as the edge transfer happens
        if (in_valid && !mode && edge_ok) begin
          adj_re    = 1'b1;
          adj_raddr = vertex_a[IW-1:0];
        end
      end
      ST_EDGE_A: begin
        adj_we    = 1'b1;
        adj_waddr = edge_a;
        adj_wdata = row_cur | (MAX_VERTICES'(1) << edge_b);
        // self loop: row a already holds the only bit to set
        if (edge_a != edge_b) begin
          adj_re    = 1'b1;
          adj_raddr = edge_b;
        end
      end
      ST_EDGE_B: begin
        adj_we    = 1'b1;
        adj_waddr = edge_b;
        adj_wdata = row_cur | (MAX_VERTICES'(1) << edge_a);
      end
      ST_SCAN: begin
        // root of the next component is the lowest unvisited live vertex
        if (cand != '0) begin
          adj_re    = 1'b1;
          adj_raddr = lb_idx;
        end
      end
      ST_PUSH: begin
        if (frontier != '0) begin
          stk_we    = 1'b1;
          stk_waddr = sp;
          stk_wdata = lb_idx;
        end else if (sp != '0) begin
          stk_re    = 1'b1;
          stk_raddr = IW'(sp - 1'b1);
        end
      end
      ST_POP: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  // controller and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      vertex_count <= VCOUNT_RESET;
      row_valid    <= '0;
      visited      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adj_re) begin
        adj_rd_ok <= row_valid[adj_raddr];
      end
      if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (mode) begin
              visited <= '0;
              best    <= '0;
              state   <= ST_SCAN;
            end else if (edge_ok) begin
              edge_a <= vertex_a[IW-1:0];
              edge_b <= vertex_b[IW-1:0];
              state  <= ST_EDGE_A;
            end
          end
        end
        ST_EDGE_A: begin
          state <= (edge_a == edge_b) ? ST_IDLE : ST_EDGE_B;
        end
        ST_EDGE_B: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (cand == '0) begin
            // walk done; wait for the output register to be free
            if (result_load) begin
              largest_size <= COUNT_W'(best);
              row_valid    <= '0;
              state        <= ST_IDLE;
            end
          end else begin
            visited[lb_idx] <= 1'b1;
            cur_count       <= CW'(1);
            sp              <= '0;
            state           <= ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          frontier <= row_cur & live & ~visited;
          state    <= ST_PUSH;
        end
        ST_PUSH: begin
          if (frontier != '0) begin
            frontier[lb_idx] <= 1'b0;
            visited[lb_idx]  <= 1'b1;
            sp               <= IW'(sp + 1'b1);
          end else if (sp != '0) begin
            sp    <= IW'(sp - 1'b1);
            state <= ST_POP;
          end else begin
            // component finished
            if (cur_count > best) begin
              best <= cur_count;
            end
            state <= ST_SCAN;
          end
        end
        ST_POP: begin
          cur_count <= CW'(cur_count + 1'b1);
          state     <= ST_EXPAND;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a vertex waiting to be pushed is never already marked visited
  a_frontier_unvisited: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> ((frontier & visited) == '0))
    else $error("frontier overlaps visited set");

  // during a walk no vertex outside the graph is marked
  a_visited_live: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_IDLE) && (state != ST_EDGE_A) && (state != ST_EDGE_B)) |->
      ((visited & ~live) == '0))
    else $error("visited vertex outside graph");

  // a component never counts more vertices than the graph has
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> (cur_count <= eff_count))
    else $error("component count exceeds vertex count");

  // a result appears only at the end of a walk
  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_SCAN))
    else $error("result raised outside walk end");

endmodule

`default_nettype wire

// ===== rtl/lcc_ram.sv =====
// lcc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module lcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcc_low_bit.sv =====
// lcc_low_bit: finds the index of the lowest set bit of a vertex set.
// No dependencies; result is meaningless for an all-zero input.
`default_nettype none

module lcc_low_bit #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic [WIDTH-1:0]         vec,
  output logic      [$clog2(WIDTH)-1:0] idx
);

  localparam int unsigned IW = $clog2(WIDTH);

  logic [WIDTH-1:0] low;

  // isolate the lowest one, then encode it with an or tree
  always_comb begin
    low = vec & (~vec + WIDTH'(1));
    idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (low[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for largest_connected_component: edge and finish transfers with random
// gaps on both sides, checked against a component-size predictor in a scoreboard
// class. Depends on lcc_pkg and the rtl of the block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcc_pkg::*;

  localparam int unsigned MAX_V         = 64;
  localparam bit          MODE_EDGE     = 1'b0;
  localparam bit          MODE_FINISH   = 1'b1;
  // random transfers that load an edge or finish a graph
  localparam int unsigned RANDOM_ITEMS  = 1400;
  // last stretch with no idling on either side
  localparam int unsigned CALM_ITEMS    = 150;
  // an edge keeps the block busy through its EDGE_A and EDGE_B states after its transfer
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned LONG_HOLD     = 2000;
  // worst case: every item a finish of 64 vertices, plus the longest sender gap
  // and the longest receiver stall per item, plus the long hold
  localparam int unsigned LIMIT         = 1_500_000;

  // component-size predictor and the queue of sizes still owed by the block
  class largest_size_board;
    logic [MAX_V-1:0]   adj_rows [MAX_V];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] pending_sizes [$];
    int                 errors;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      count_reg = VCOUNT_RESET;
      errors = 0;
    endfunction

    // count of zero acts as one vertex, anything above the maximum as the maximum
    function int unsigned live_count();
      if (count_reg < 1) return 1;
      if (count_reg > MAX_V) return MAX_V;
      return int'(count_reg);
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      count_reg = value;
    endfunction

    function int unsigned pending();
      return pending_sizes.size();
    endfunction

    // depth-first walk from each unvisited vertex in ascending order
    function logic [COUNT_W-1:0] largest_component();
      int unsigned        n;
      logic [MAX_V-1:0]   live, seen, nb;
      logic [VIDX_W-1:0]  walk [MAX_V];
      int                 sp, s, u, w;
      logic [COUNT_W-1:0] size, best;
      n = live_count();
      live = (n >= MAX_V) ? '1 : ((64'd1 << n) - 64'd1);
      seen = '0;
      best = '0;
      for (s = 0; s < n; s++) begin
        if (seen[s]) continue;
        seen[s] = 1'b1;
        walk[0] = VIDX_W'(s);
        sp = 1;
        size = '0;
        while (sp > 0) begin
          sp--;
          u = int'(walk[sp]);
          size++;
          nb = adj_rows[u] & live & ~seen;
          for (w = 0; w < MAX_V; w++) begin
            if (nb[w]) begin
              seen[w] = 1'b1;
              walk[sp] = VIDX_W'(w);
              sp++;
            end
          end
        end
        if (size > best) best = size;
      end
      return best;
    endfunction

    function void note_item(bit m, logic [VIDX_W-1:0] a, logic [VIDX_W-1:0] b);
      int unsigned n;
      n = live_count();
      if (m == MODE_EDGE) begin
        if (a < n && b < n) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
        end
      end else begin
        pending_sizes.push_back(largest_component());
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
    endfunction

    function void check_result(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (pending_sizes.size() == 0) begin
        $error("largest_size: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = pending_sizes.pop_front();
      if (got !== want) begin
        $error("largest_size: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [VIDX_W-1:0]  vertex_a;
  logic [VIDX_W-1:0]  vertex_b;
  logic               out_valid;
  logic               out_ready;
  logic [COUNT_W-1:0] largest_size;

  largest_size_board board = new();

  // hold and quiet flags shared between the sender and the receiver process, plus counters
  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_active = 1'b0;
  int unsigned item_total  = 0;
  int unsigned cycle_count = 0;

  largest_connected_component #(
    .MAX_VERTICES(MAX_V)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .vertex_a    (vertex_a),
    .vertex_b    (vertex_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .largest_size(largest_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one item and hold it until the transfer, valid stays high afterwards
  task automatic send_item(input bit m, input logic [VIDX_W-1:0] a,
                           input logic [VIDX_W-1:0] b);
    in_valid <= 1'b1;
    mode     <= m;
    vertex_a <= a;
    vertex_b <= b;
    do @(posedge clk); while (!in_ready);
    board.note_item(m, a, b);
  endtask

  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  // stop offering, wait for every owed result, then let the last edge finish
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called once the block is idle
  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_count(value);
    cfg_valid <= 1'b0;
  endtask

  // mostly ordinary sizes, with zero, one, two, the maximum and above it mixed in
  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd64;
      4:       return COUNT_W'($urandom_range(65, 127));
      default: return COUNT_W'($urandom_range(3, 63));
    endcase
  endfunction

  task automatic directed_checks();
    // reset count of 64 and nothing loaded: every vertex alone
    send_item(MODE_FINISH, 6'd0, 6'd0);
    // extreme indices chained through vertex 63, plus a self loop
    send_item(MODE_EDGE, 6'd0, 6'd63);
    send_item(MODE_EDGE, 6'd63, 6'd1);
    send_item(MODE_EDGE, 6'd5, 6'd5);
    send_item(MODE_FINISH, 6'd63, 6'd63);
    // count of zero acts as a single vertex, edge to vertex 1 is dropped
    hold_until_drained();
    write_count(7'd0);
    send_item(MODE_EDGE, 6'd0, 6'd0);
    send_item(MODE_EDGE, 6'd0, 6'd1);
    send_item(MODE_FINISH, 6'd0, 6'd0);
    // count above the maximum acts as 64
    hold_until_drained();
    write_count(7'd127);
    send_item(MODE_EDGE, 6'd62, 6'd63);
    send_item(MODE_EDGE, 6'd63, 6'd61);
    send_item(MODE_FINISH, 6'd0, 6'd0);
    // count shrinks between loading and finish: edge to 40 falls outside the walk
    hold_until_drained();
    write_count(7'd64);
    send_item(MODE_EDGE, 6'd1, 6'd2);
    send_item(MODE_EDGE, 6'd2, 6'd40);
    send_item(MODE_EDGE, 6'd3, 6'd4);
    hold_until_drained();
    write_count(7'd10);
    send_item(MODE_FINISH, 6'd0, 6'd0);
    // endpoints at the bound are dropped, last in-range vertex kept
    hold_until_drained();
    write_count(7'd8);
    send_item(MODE_EDGE, 6'd7, 6'd8);
    send_item(MODE_EDGE, 6'd8, 6'd8);
    send_item(MODE_EDGE, 6'd0, 6'd7);
    send_item(MODE_EDGE, 6'd9, 6'd3);
    send_item(MODE_FINISH, 6'd0, 6'd0);
  endtask

  // one graph: optional count change, random edges, optional late change, finish
  task automatic random_graph();
    int unsigned       n, edges, roll, i;
    logic [VIDX_W-1:0] a, b;
    bit                gappy;
    gappy = !quiet && ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 2) == 0) begin
      hold_until_drained();
      write_count(pick_count());
    end
    n = board.live_count();
    edges = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                        : $urandom_range(0, 2 * n);
    for (i = 0; i < edges; i++) begin
      roll = $urandom_range(0, 19);
      if (roll < 11) begin
        a = VIDX_W'($urandom_range(0, n - 1));
        b = VIDX_W'($urandom_range(0, n - 1));
      end else if (roll < 16) begin
        // neighbor chains grow long components
        a = VIDX_W'($urandom_range(0, n - 1));
        b = (a + 1 < n) ? VIDX_W'(a + 1) : '0;
      end else if (roll < 18) begin
        // anywhere in the field, often out of range
        a = VIDX_W'($urandom_range(0, MAX_V - 1));
        b = VIDX_W'($urandom_range(0, MAX_V - 1));
      end else begin
        a = VIDX_W'($urandom_range(0, n - 1));
        b = a;
      end
      send_item(MODE_EDGE, a, b);
      item_total++;
      if (gappy && $urandom_range(0, 3) == 0) sender_gap();
    end
    if ($urandom_range(0, 7) == 0) begin
      hold_until_drained();
      write_count(pick_count());
    end
    send_item(MODE_FINISH, VIDX_W'($urandom_range(0, MAX_V - 1)),
              VIDX_W'($urandom_range(0, MAX_V - 1)));
    item_total++;
    if (gappy && $urandom_range(0, 3) == 0) sender_gap();
  endtask

  // receiver holds off for a long time while finishes and edges keep coming,
  // so the output register fills and the input stalls
  task automatic fill_and_stall();
    int unsigned       n, i, k;
    logic [VIDX_W-1:0] a;
    hold_until_drained();
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    n = board.live_count();
    for (k = 0; k < 3; k++) begin
      for (i = 0; i < 12; i++) begin
        a = VIDX_W'($urandom_range(0, n - 1));
        send_item(MODE_EDGE, a, VIDX_W'($urandom_range(0, n - 1)));
        item_total++;
      end
      send_item(MODE_FINISH, 6'd0, 6'd0);
      item_total++;
    end
    // sender waits for every owed result before going on
    hold_until_drained();
  endtask

  // receiver: random stalls, one long hold on request, none near the end
  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // every result transfer is checked against the oldest owed size
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(largest_size);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sender: reset, directed graphs, random graphs with one fill and stall, then drain and report
  initial begin
    bit stalled_once;
    stalled_once = 1'b0;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    mode      <= MODE_EDGE;
    vertex_a  <= '0;
    vertex_b  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    while (item_total < RANDOM_ITEMS) begin
      quiet = (item_total >= RANDOM_ITEMS - CALM_ITEMS);
      if (!stalled_once && item_total >= RANDOM_ITEMS / 2) begin
        fill_and_stall();
        stalled_once = 1'b1;
      end
      random_graph();
    end
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
